@@ rtl/slot_free_list_allocator_defines.svh @@
// ----------------------------------------------------------------------------
// Slot free-list allocator: assertion macros
// Shared property wrappers for the allocator's RTL checks.
// ----------------------------------------------------------------------------
`ifndef SLOT_FREE_LIST_ALLOCATOR_DEFINES_SVH
`define SLOT_FREE_LIST_ALLOCATOR_DEFINES_SVH

// Check on every edge outside reset.
`define SLFA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check on every edge, reset included.
`define SLFA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ rtl/slfa_pkg.sv @@
// ----------------------------------------------------------------------------
// Slot free-list allocator package
// Sizes, link and status codes, FSM states and link-table helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package slfa_pkg;

  localparam int unsigned CAPACITY = 64;
  localparam int unsigned IDX_W    = $clog2(CAPACITY);
  localparam int unsigned LINK_W   = IDX_W + 1;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [LINK_W-1:0] link_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  // Both links of an allocated slot hold this marker.
  localparam link_t IN_USE_MARK = link_t'(CAPACITY);
  localparam cnt_t  CNT_FULL    = cnt_t'(CAPACITY);

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_FULL     = 2'd1,
    STAT_NOT_USED = 2'd2
  } status_e;

  typedef enum logic {
    FUNC_ALLOC = 1'b0,
    FUNC_FREE  = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_LINK = 2'd1,
    ST_FIN  = 2'd2
  } state_e;

  typedef struct packed {
    logic  we;
    idx_t  addr;
    link_t data;
  } link_wr_t;

  function automatic idx_t clamp_link(input link_t v);
    clamp_link = (v < link_t'(CAPACITY)) ? v[IDX_W-1:0] : '0;
  endfunction

  function automatic link_t next_reset(input idx_t i);
    next_reset = (i == idx_t'(CAPACITY - 1)) ? '0 : link_t'(i) + link_t'(1);
  endfunction

  function automatic link_t prev_reset(input idx_t i);
    prev_reset = (i == '0) ? link_t'(CAPACITY - 1) : link_t'(i) - link_t'(1);
  endfunction

endpackage

`default_nettype wire

@@ rtl/slfa_link_mem.sv @@
// ----------------------------------------------------------------------------
// Slot free-list allocator: link table
// One-write, one-read synchronous link memory with per-entry written bits
// and same-cycle write forwarding onto the registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module slfa_link_mem (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  slfa_pkg::link_wr_t wr_i,
  input  slfa_pkg::idx_t     raddr_i,
  output slfa_pkg::link_t    rdata_o,
  output logic               written_o
);
  import slfa_pkg::*;

  link_t               mem_q [CAPACITY];
  logic [CAPACITY-1:0] written_q;
  link_t               rd_q;
  link_t               fwd_data_q;
  logic                fwd_q;
  logic                rd_written_q;
  logic                hit;

  assign hit = wr_i.we && (wr_i.addr == raddr_i);

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    rd_q       <= mem_q[raddr_i];
    fwd_data_q <= wr_i.data;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q    <= '0;
      fwd_q        <= 1'b0;
      rd_written_q <= 1'b0;
    end else begin
      if (wr_i.we) begin
        written_q[wr_i.addr] <= 1'b1;
      end
      fwd_q        <= hit;
      rd_written_q <= written_q[raddr_i] | hit;
    end
  end

  // Prefer data written in the read cycle over the stale array word.
  assign rdata_o   = fwd_q ? fwd_data_q : rd_q;
  assign written_o = rd_written_q;

endmodule

`default_nettype wire

@@ rtl/slot_free_list_allocator.sv @@
// ----------------------------------------------------------------------------
// Slot free-list allocator
// Hands out and takes back slots of a fixed pool kept on a circular doubly
// linked free list in two link memories.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. The links are read
// in the cycle of acceptance, relinked in the next cycle, and the result is
// shown with done_o for one cycle after that; the next request may be taken
// in that same cycle, so a steady stream runs at two cycles per request.
// The figure comes from the single write port of each link memory: every
// request writes up to two entries of each table, one per cycle. A read that
// meets the second write to the same entry is served by forwarding. There is
// no way to hold a result off: it must be taken in its done_o cycle. No
// clearing pass is needed after reset; the pool is ready at once.
`default_nettype none

`include "slot_free_list_allocator_defines.svh"

module slot_free_list_allocator (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  logic                    func_i,
  input  logic [5:0]              slot_to_free_i,
  output logic                    done_o,
  output logic [5:0]              granted_slot_o,
  output logic [1:0]              status_o,
  output logic [6:0]              used_count_o,
  output logic [6:0]              high_water_o
);
  import slfa_pkg::*;

  state_e   state_q, state_d;
  logic     accept;

  logic     func_q;
  idx_t     slot_q;
  idx_t     head_q, head_d;
  cnt_t     count_q, count_d;
  cnt_t     high_q, high_d;
  idx_t     granted_q, granted_d;
  status_e  status_q, status_d;

  link_wr_t nx_wr1, pv_wr1, nx_wr2_d, pv_wr2_d, nx_wr2_q, pv_wr2_q;
  link_wr_t nx_wr, pv_wr;

  idx_t     pv_raddr;
  link_t    nx_rdata, pv_rdata;
  logic     nx_written, pv_written;
  link_t    next_lk, prev_lk;

  logic     full;
  idx_t     got, p_idx, n_idx, after;

  assign accept = start && !busy;

  // ---- state machine ------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (accept) state_d = ST_LINK;
      ST_LINK: state_d = ST_FIN;
      ST_FIN:  state_d = accept ? ST_LINK : ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    busy   = (state_q == ST_LINK);
    done_o = (state_q == ST_FIN);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // ---- link memories ------------------------------------------------------
  // Next link is always read at the head; prev link at the slot on a free
  // (marker test) and at the head on an allocate.
  assign pv_raddr = (func_e'(func_i) == FUNC_FREE) ? slot_to_free_i : head_q;

  always_comb begin
    nx_wr = '0;
    pv_wr = '0;
    case (state_q)
      ST_LINK: begin
        nx_wr = nx_wr1;
        pv_wr = pv_wr1;
      end
      ST_FIN: begin
        nx_wr = nx_wr2_q;
        pv_wr = pv_wr2_q;
      end
      default: begin
        nx_wr = '0;
        pv_wr = '0;
      end
    endcase
  end

  slfa_link_mem u_next_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (nx_wr),
    .raddr_i   (head_q),
    .rdata_o   (nx_rdata),
    .written_o (nx_written)
  );

  slfa_link_mem u_prev_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (pv_wr),
    .raddr_i   (pv_raddr),
    .rdata_o   (pv_rdata),
    .written_o (pv_written)
  );

  // Entries never written read as their reset links.
  assign next_lk = nx_written ? nx_rdata : next_reset(head_q);
  assign prev_lk = pv_written ? pv_rdata
                 : prev_reset((func_e'(func_q) == FUNC_FREE) ? slot_q : head_q);

  // ---- relink -------------------------------------------------------------
  assign full  = (count_q == CNT_FULL);
  assign got   = head_q;
  assign p_idx = clamp_link(prev_lk);
  assign n_idx = clamp_link(next_lk);
  assign after = clamp_link(next_lk);

  always_comb begin
    nx_wr1    = '0;
    pv_wr1    = '0;
    nx_wr2_d  = '0;
    pv_wr2_d  = '0;
    head_d    = head_q;
    count_d   = count_q;
    high_d    = high_q;
    granted_d = '0;
    status_d  = STAT_OK;
    if (func_e'(func_q) == FUNC_ALLOC) begin
      if (full) begin
        status_d = STAT_FULL;
      end else begin
        nx_wr1 = '{we: 1'b1, addr: got, data: IN_USE_MARK};
        pv_wr1 = '{we: 1'b1, addr: got, data: IN_USE_MARK};
        // Unlink unless this is the last free slot.
        if (p_idx != got) begin
          head_d   = n_idx;
          nx_wr2_d = '{we: 1'b1, addr: p_idx, data: link_t'(n_idx)};
          pv_wr2_d = '{we: 1'b1, addr: n_idx, data: link_t'(p_idx)};
        end
        count_d = count_q + cnt_t'(1);
        if (cnt_t'(got) >= high_q) begin
          high_d = cnt_t'(got) + cnt_t'(1);
        end
        granted_d = got;
      end
    end else begin
      if (prev_lk != IN_USE_MARK) begin
        status_d = STAT_NOT_USED;
      end else begin
        if (full) begin
          // Start a one-element list.
          nx_wr1 = '{we: 1'b1, addr: slot_q, data: link_t'(slot_q)};
          pv_wr1 = '{we: 1'b1, addr: slot_q, data: link_t'(slot_q)};
          head_d = slot_q;
        end else begin
          nx_wr1   = '{we: 1'b1, addr: head_q, data: link_t'(slot_q)};
          pv_wr1   = '{we: 1'b1, addr: after, data: link_t'(slot_q)};
          nx_wr2_d = '{we: 1'b1, addr: slot_q, data: link_t'(after)};
          pv_wr2_d = '{we: 1'b1, addr: slot_q, data: link_t'(head_q)};
          if (slot_q < head_q) begin
            head_d = slot_q;
          end
        end
        if (count_q != '0) begin
          count_d = count_q - cnt_t'(1);
        end
      end
    end
  end

  // ---- registers ----------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q <= func_i;
      slot_q <= slot_to_free_i;
    end
    if (state_q == ST_LINK) begin
      granted_q <= granted_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q   <= '0;
      count_q  <= '0;
      high_q   <= '0;
      status_q <= STAT_OK;
      nx_wr2_q <= '0;
      pv_wr2_q <= '0;
    end else if (state_q == ST_LINK) begin
      head_q   <= head_d;
      count_q  <= count_d;
      high_q   <= high_d;
      status_q <= status_d;
      nx_wr2_q <= nx_wr2_d;
      pv_wr2_q <= pv_wr2_d;
    end
  end

  assign granted_slot_o = granted_q;
  assign status_o       = status_q;
  assign used_count_o   = count_q;
  assign high_water_o   = high_q;

  // ---- checks -------------------------------------------------------------
  `SLFA_ASSERT_ALWAYS(a_count_bound, !rst_ni || count_q <= CNT_FULL, "used count above capacity")
  `SLFA_ASSERT(a_high_mono, 1'b1 |=> high_q >= $past(high_q), "high-water mark fell")
  `SLFA_ASSERT(a_full_status, done_o && status_q == STAT_FULL |-> count_q == CNT_FULL,
               "full status with free slots left")
  `SLFA_ASSERT(a_grant_below_high, done_o && status_q == STAT_OK |-> cnt_t'(granted_q) < high_q,
               "successful request not below high-water mark")

endmodule

`default_nettype wire

@@ tb/slot_free_list_allocator_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slot free-list allocator testbench
// Streams allocate and free requests through the allocator and checks every
// result against a cycle-free model of the linked free list: directed corner
// requests first, then random phases that fill the pool, drain it, churn it
// and throw raw noise at it, under bursty request timing.
// ----------------------------------------------------------------------------
module slot_free_list_allocator_tb;
  import slfa_pkg::*;

  localparam int unsigned TARGET_ITEMS = 1300;
  localparam int unsigned LIMIT_CYCLES = 200000;

  // Link tables and counters of the pool, as the block should hold them.
  typedef struct packed {
    link_t [CAPACITY-1:0] nxt;
    link_t [CAPACITY-1:0] prv;
    idx_t                 head;
    cnt_t                 used;
    cnt_t                 hwm;
  } pool_t;

  typedef struct packed {
    idx_t    granted;
    status_e status;
    cnt_t    used;
    cnt_t    hwm;
  } alloc_result_t;

  typedef struct packed {
    logic  drain_first;
    func_e fn;
    idx_t  slot;
  } request_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  logic       func_i = 1'b0;
  logic [5:0] slot_to_free_i = '0;
  logic       done_o;
  logic [5:0] granted_slot_o;
  logic [1:0] status_o;
  logic [6:0] used_count_o;
  logic [6:0] high_water_o;

  request_t      req_queue[$];
  alloc_result_t predicted_grants[$];
  pool_t         model_pool;
  pool_t         plan_pool;

  logic        req_accepted = 1'b0;
  logic        pause_next;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  int unsigned cycle_count = 0;
  int unsigned err_count = 0;
  int unsigned n_queued = 0;
  int unsigned n_alloc_ok = 0;
  int unsigned n_free_ok = 0;
  int unsigned n_full = 0;
  int unsigned n_not_used = 0;
  int unsigned peak_used = 0;
  int unsigned peak_hwm = 0;

  slot_free_list_allocator i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .func_i         (func_i),
    .slot_to_free_i (slot_to_free_i),
    .done_o         (done_o),
    .granted_slot_o (granted_slot_o),
    .status_o       (status_o),
    .used_count_o   (used_count_o),
    .high_water_o   (high_water_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  function automatic pool_t fresh_pool();
    pool_t p;
    p = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      p.nxt[i] = link_t'((i + 1) % CAPACITY);
      p.prv[i] = link_t'((i + CAPACITY - 1) % CAPACITY);
    end
    return p;
  endfunction

  function automatic idx_t link_to_idx(input link_t v);
    return (v < link_t'(CAPACITY)) ? idx_t'(v) : idx_t'(0);
  endfunction

  // Apply one request to the pool and return the result it should produce.
  function automatic alloc_result_t serve_request(inout pool_t p, input func_e fn,
                                                  input idx_t slot);
    alloc_result_t r;
    idx_t got, pv, nx, bf, af;
    r = '0;
    r.status = STAT_OK;
    if (fn == FUNC_ALLOC) begin
      if (p.used >= CNT_FULL) begin
        r.status = STAT_FULL;
      end else begin
        got = p.head;
        pv  = link_to_idx(p.prv[got]);
        nx  = link_to_idx(p.nxt[got]);
        // last free slot: nothing to relink, head stays put
        if (pv != got) begin
          p.head   = nx;
          p.nxt[pv] = link_t'(nx);
          p.prv[nx] = link_t'(pv);
        end
        p.nxt[got] = IN_USE_MARK;
        p.prv[got] = IN_USE_MARK;
        p.used     = p.used + cnt_t'(1);
        if (cnt_t'(got) >= p.hwm) p.hwm = cnt_t'(got) + cnt_t'(1);
        r.granted = got;
      end
    end else begin
      if (p.nxt[slot] != IN_USE_MARK) begin
        r.status = STAT_NOT_USED;
      end else begin
        if (p.used >= CNT_FULL) begin
          // freeing into a full pool starts a one-slot list
          p.nxt[slot] = link_t'(slot);
          p.prv[slot] = link_t'(slot);
          p.head      = slot;
        end else begin
          bf = p.head;
          af = link_to_idx(p.nxt[bf]);
          p.nxt[bf]   = link_t'(slot);
          p.prv[af]   = link_t'(slot);
          p.nxt[slot] = link_t'(af);
          p.prv[slot] = link_t'(bf);
          if (slot < p.head) p.head = slot;
        end
        if (p.used > 0) p.used = p.used - cnt_t'(1);
      end
    end
    r.used = p.used;
    r.hwm  = p.hwm;
    return r;
  endfunction

  function automatic idx_t pick_used_slot(input pool_t p);
    idx_t s;
    do begin
      s = idx_t'($urandom_range(0, CAPACITY - 1));
    end while (p.nxt[s] != IN_USE_MARK);
    return s;
  endfunction

  task automatic push_request(input func_e fn, input idx_t slot);
    request_t item;
    item.drain_first = pause_next;
    item.fn          = fn;
    item.slot        = slot;
    req_queue.push_back(item);
    void'(serve_request(plan_pool, fn, slot));
    pause_next = 1'b0;
    n_queued++;
  endtask

  task automatic push_alloc();
    push_request(FUNC_ALLOC, idx_t'($urandom_range(0, CAPACITY - 1)));
  endtask

  // Driver: hold the item until taken, then feed the next one in bursts.
  always @(negedge clk_i) begin
    request_t item;
    if (rst_ni && !(start && !req_accepted)) begin
      if (gap_left != 0) begin
        gap_left = gap_left - 1;
        start <= 1'b0;
      end else if (req_queue.size() != 0 &&
                   !(req_queue[0].drain_first && predicted_grants.size() != 0)) begin
        item = req_queue.pop_front();
        func_i         <= item.fn;
        slot_to_free_i <= item.slot;
        start          <= 1'b1;
        req_accepted = 1'b0;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
        end else begin
          burst_left = burst_left - 1;
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: check the result shown this cycle, then record any item taken.
  always @(posedge clk_i) begin
    alloc_result_t want;
    if (rst_ni) begin
      if (done_o) begin
        if (predicted_grants.size() == 0) begin
          $display("%0t: unexpected result: slot %0d status %0d used %0d high %0d",
                   $time, granted_slot_o, status_o, used_count_o, high_water_o);
          err_count++;
        end else begin
          want = predicted_grants.pop_front();
          if (granted_slot_o !== want.granted) begin
            $display("%0t: granted_slot expected %0d, actual %0d",
                     $time, want.granted, granted_slot_o);
            err_count++;
          end
          if (status_o !== want.status) begin
            $display("%0t: status expected %0d, actual %0d", $time, want.status, status_o);
            err_count++;
          end
          if (used_count_o !== want.used) begin
            $display("%0t: used_count expected %0d, actual %0d",
                     $time, want.used, used_count_o);
            err_count++;
          end
          if (high_water_o !== want.hwm) begin
            $display("%0t: high_water expected %0d, actual %0d",
                     $time, want.hwm, high_water_o);
            err_count++;
          end
          case (want.status)
            STAT_FULL:     n_full++;
            STAT_NOT_USED: n_not_used++;
            default: begin
              if (want.used > peak_used) peak_used = int'(want.used);
            end
          endcase
          if (want.hwm > peak_hwm) peak_hwm = int'(want.hwm);
        end
      end
      if (start && !busy) begin
        if (func_e'(func_i) == FUNC_ALLOC) begin
          predicted_grants.push_back(serve_request(model_pool, FUNC_ALLOC, slot_to_free_i));
          if (predicted_grants[$].status == STAT_OK) n_alloc_ok++;
        end else begin
          predicted_grants.push_back(serve_request(model_pool, FUNC_FREE, slot_to_free_i));
          if (predicted_grants[$].status == STAT_OK) n_free_ok++;
        end
        req_accepted = 1'b1;
      end
    end
  end

  initial begin
    wait (cycle_count >= LIMIT_CYCLES);
    $display("%0t: timeout after %0d cycles", $time, cycle_count);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    int unsigned phase_len;
    int unsigned mode;
    model_pool = fresh_pool();
    plan_pool  = fresh_pool();
    pause_next = 1'b0;

    // Directed corners on a fresh pool.
    push_request(FUNC_FREE, 6'd0);     // free while nothing is in use
    push_request(FUNC_ALLOC, 6'd0);
    push_request(FUNC_ALLOC, 6'h3F);   // ignored index, all ones
    push_request(FUNC_ALLOC, 6'h2A);
    push_request(FUNC_ALLOC, 6'h15);
    push_request(FUNC_FREE, 6'd2);     // below the head: becomes head
    push_request(FUNC_FREE, 6'd2);     // double free
    push_request(FUNC_FREE, 6'd63);    // never allocated
    push_request(FUNC_ALLOC, 6'd0);
    push_request(FUNC_FREE, 6'd3);
    push_request(FUNC_FREE, 6'd0);
    push_request(FUNC_ALLOC, 6'd0);
    push_request(FUNC_ALLOC, 6'd0);
    push_request(FUNC_FREE, 6'd1);
    push_request(FUNC_FREE, 6'd2);
    push_request(FUNC_FREE, 6'd3);     // still free here: a bad free
    push_request(FUNC_ALLOC, 6'd0);
    push_request(FUNC_FREE, 6'd0);
    push_request(FUNC_FREE, 6'd1);

    // Random phases; the first one waits for the pipe to empty and fills the pool.
    pause_next = 1'b1;
    mode = 0;
    while (n_queued < TARGET_ITEMS) begin
      case (mode)
        0, 1: begin
          // fill to full, knock on the full pool, then free into it
          while (plan_pool.used < CNT_FULL) push_alloc();
          repeat ($urandom_range(1, 3)) push_alloc();
          push_request(FUNC_FREE, pick_used_slot(plan_pool));
          push_alloc();                 // takes the one-slot list
          push_alloc();
          repeat ($urandom_range(1, 4)) push_request(FUNC_FREE, pick_used_slot(plan_pool));
        end
        2, 3: begin
          // drain to empty with some bad frees mixed in
          while (plan_pool.used != 0) begin
            if ($urandom_range(0, 9) == 0)
              push_request(FUNC_FREE, idx_t'($urandom_range(0, CAPACITY - 1)));
            else
              push_request(FUNC_FREE, pick_used_slot(plan_pool));
          end
          push_request(FUNC_FREE, idx_t'($urandom_range(0, CAPACITY - 1)));
          repeat ($urandom_range(1, 5)) push_alloc();
        end
        4, 5, 6, 7, 8: begin
          phase_len = $urandom_range(20, 80);
          repeat (phase_len) begin
            if (plan_pool.used == 0)
              push_alloc();
            else if ($urandom_range(0, 12) == 0)
              push_request(FUNC_FREE, idx_t'($urandom_range(0, CAPACITY - 1)));
            else if (plan_pool.used >= CNT_FULL || $urandom_range(0, 99) >= 55)
              push_request(FUNC_FREE, pick_used_slot(plan_pool));
            else
              push_alloc();
          end
        end
        default: begin
          phase_len = $urandom_range(10, 30);
          repeat (phase_len)
            push_request(func_e'($urandom_range(0, 1)), idx_t'($urandom_range(0, CAPACITY - 1)));
        end
      endcase
      pause_next = ($urandom_range(0, 3) == 0);
      mode = $urandom_range(0, 9);
    end

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (req_queue.size() != 0 || start || predicted_grants.size() != 0)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Ran %0d requests: %0d grants, %0d frees, %0d full refusals, %0d bad frees",
             n_queued, n_alloc_ok, n_free_ok, n_full, n_not_used);
    $display("Peak occupancy %0d of %0d slots, high-water mark reached %0d",
             peak_used, CAPACITY, peak_hwm);
    if (err_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
